>>> rtl/ttl_pkg.sv
`timescale 1ns / 1ps

package ttl_pkg;

  localparam int unsigned MAX_STRING_LEN  = 256;
  localparam int unsigned MAX_FRAC_DIGITS = 9;
  localparam int unsigned LINE_BITS       = 24;

  localparam int unsigned LEN_W   = $clog2(MAX_STRING_LEN) + 1;
  localparam int unsigned MAG_W   = 31;
  localparam int unsigned FRAC_W  = 30;
  localparam int unsigned FCNT_W  = 4;
  localparam int unsigned LINE_W  = 24;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned KIND_W  = 3;

  localparam int unsigned OUT_DATA_W = 104;
  localparam int unsigned IN_DATA_W  = 8;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [MAG_W-1:0]     MAG_MAX  = {MAG_W{1'b1}};
  localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
  localparam logic [LEN_W-1:0]     LEN_LIMIT = LEN_W'(MAX_STRING_LEN - 1);
  localparam logic [FCNT_W-1:0]    FRAC_LIMIT = FCNT_W'(MAX_FRAC_DIGITS);

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_STRING  = 2'd1,
    MODE_NUMBER  = 2'd2,
    MODE_COMMENT = 2'd3
  } mode_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_STR_CHAR = 3'd0,
    KIND_STR_END  = 3'd1,
    KIND_COMMAND  = 3'd2,
    KIND_INTEGER  = 3'd3,
    KIND_FLOAT    = 3'd4,
    KIND_INVALID  = 3'd5,
    KIND_END      = 3'd6
  } kind_e;

  typedef struct packed {
    kind_e               kind;
    logic [CHAR_W-1:0]   char_code;
    logic [MAG_W-1:0]    magnitude;
    logic                is_negative;
    logic [FRAC_W-1:0]   fraction_digits;
    logic [FCNT_W-1:0]   fraction_count;
    logic [LINE_W-1:0]   line_number;
    logic                last;
  } result_t;

  typedef struct packed {
    logic    push;
    logic    two;
    result_t r0;
    result_t r1;
  } push_t;

endpackage

>>> rtl/text_token_lexer.sv
`timescale 1ns / 1ps

// Byte-serial text lexer. One byte (or an end-of-input mark) is taken per
// cycle; each beat is decoded combinationally against the lexer mode and
// yields zero to two result beats, which go through a four-entry output
// queue. Input is accepted whenever the queue has room for two results, so
// the sustained rate is one byte per cycle while the output side keeps up;
// a byte that yields two results (a terminator emitting both the pending
// token and its own) pushes both into the queue together. The byte that ends
// a string or number is then handled as in idle mode and may start the next
// token. tlast marks the final result of each input byte.
module text_token_lexer (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // byte_in[7:0]
  input  logic [0:0]   s_axis_tuser,   // end_of_input[0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // char_code[7:0], magnitude[38:8], is_negative[39], fraction_digits[69:40],
  // fraction_count[73:70], line_number[97:74], zero[103:98]
  output logic [ttl_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic [ttl_pkg::KIND_W-1:0]     m_axis_tuser,   // kind[2:0]
  output logic                           m_axis_tlast
);

  ttl_pkg::push_t   push;
  ttl_pkg::result_t head;
  logic             fire;

  assign fire = s_axis_tvalid && s_axis_tready;

  ttl_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (s_axis_tdata),
    .eoi_i  (s_axis_tuser[0]),
    .push_o (push)
  );

  ttl_out_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (s_axis_tready),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (head)
  );

  assign m_axis_tdata = {6'd0, head.line_number, head.fraction_count, head.fraction_digits,
                         head.is_negative, head.magnitude, head.char_code};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

endmodule

>>> rtl/ttl_core.sv
`timescale 1ns / 1ps

module ttl_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  logic [7:0]     byte_i,
  input  logic           eoi_i,
  output ttl_pkg::push_t push_o
);

  ttl_pkg::mode_e                   mode_q, mode_d;
  logic [ttl_pkg::LEN_W-1:0]        len_q, len_d;
  logic [ttl_pkg::MAG_W-1:0]        int_q, int_d;
  logic                             minus_q, minus_d;
  logic                             dot_q, dot_d;
  logic [ttl_pkg::FRAC_W-1:0]       frac_q, frac_d;
  logic [ttl_pkg::FCNT_W-1:0]       fcnt_q, fcnt_d;
  logic [ttl_pkg::LINE_BITS-1:0]    line_q, line_d;
  logic [ttl_pkg::LINE_BITS-1:0]    tline_q, tline_d;

  logic is_letter, is_digit, is_space, is_str_char, is_str_start;
  logic [3:0] digit;
  logic [ttl_pkg::MAG_W+3:0] int_mul;
  logic [ttl_pkg::FRAC_W-1:0] frac_mul;

  assign is_letter = (byte_i >= 8'h61 && byte_i <= 8'h7A) ||
                     (byte_i >= 8'h41 && byte_i <= 8'h5A);
  assign is_digit  = byte_i >= ttl_pkg::CH_ZERO && byte_i <= ttl_pkg::CH_NINE;
  assign is_space  = byte_i == ttl_pkg::CH_SPACE || byte_i == ttl_pkg::CH_TAB ||
                     byte_i == ttl_pkg::CH_LF || byte_i == ttl_pkg::CH_CR;
  assign is_str_start = is_letter || byte_i == ttl_pkg::CH_UNDER ||
                        byte_i == ttl_pkg::CH_QUEST;
  assign is_str_char = is_str_start || is_digit || byte_i == ttl_pkg::CH_DOT ||
                       byte_i == ttl_pkg::CH_SLASH || byte_i == ttl_pkg::CH_BSL ||
                       byte_i == ttl_pkg::CH_HASH;
  assign digit    = 4'(byte_i - ttl_pkg::CH_ZERO);
  assign int_mul  = {4'd0, int_q} * (ttl_pkg::MAG_W+4)'(10)
                    + (ttl_pkg::MAG_W+4)'(digit);
  assign frac_mul = frac_q * ttl_pkg::FRAC_W'(10) + ttl_pkg::FRAC_W'(digit);

  // decode: what this beat does
  logic str_cont, num_dot, num_digit, do_idle, pre_valid;

  always_comb begin
    str_cont  = 1'b0;
    num_dot   = 1'b0;
    num_digit = 1'b0;
    do_idle   = 1'b0;
    pre_valid = 1'b0;
    if (eoi_i) begin
      pre_valid = (mode_q == ttl_pkg::MODE_STRING) || (mode_q == ttl_pkg::MODE_NUMBER);
    end else begin
      unique case (mode_q)
        ttl_pkg::MODE_STRING: begin
          if (is_str_char && len_q < ttl_pkg::LEN_LIMIT) begin
            str_cont = 1'b1;
          end else begin
            pre_valid = 1'b1;
            do_idle   = 1'b1;
          end
        end
        ttl_pkg::MODE_NUMBER: begin
          if (byte_i == ttl_pkg::CH_DOT && !dot_q) begin
            num_dot = 1'b1;
          end else if (is_digit) begin
            num_digit = 1'b1;
          end else begin
            pre_valid = 1'b1;
            do_idle   = 1'b1;
          end
        end
        ttl_pkg::MODE_COMMENT: begin
          do_idle = byte_i == ttl_pkg::CH_LF || byte_i == ttl_pkg::CH_CR;
        end
        default: begin
          do_idle = 1'b1;
        end
      endcase
    end
  end

  // outputs
  ttl_pkg::result_t pre_res, main_res, blank;
  logic main_valid;

  always_comb begin
    blank            = '0;
    blank.kind       = ttl_pkg::KIND_END;
    pre_res          = blank;
    pre_res.line_number = ttl_pkg::LINE_W'(tline_q);
    if (mode_q == ttl_pkg::MODE_NUMBER) begin
      pre_res.magnitude   = int_q;
      pre_res.is_negative = minus_q;
      if (dot_q) begin
        pre_res.kind            = ttl_pkg::KIND_FLOAT;
        pre_res.fraction_digits = frac_q;
        pre_res.fraction_count  = fcnt_q;
      end else begin
        pre_res.kind = ttl_pkg::KIND_INTEGER;
      end
    end else begin
      pre_res.kind = ttl_pkg::KIND_STR_END;
    end

    main_valid           = 1'b0;
    main_res             = blank;
    main_res.line_number = ttl_pkg::LINE_W'(line_q);
    if (eoi_i) begin
      main_valid    = 1'b1;
      main_res.kind = ttl_pkg::KIND_END;
    end else if (str_cont) begin
      main_valid           = 1'b1;
      main_res.kind        = ttl_pkg::KIND_STR_CHAR;
      main_res.char_code   = byte_i;
      main_res.line_number = ttl_pkg::LINE_W'(tline_q);
    end else if (do_idle) begin
      if (is_str_start) begin
        main_valid         = 1'b1;
        main_res.kind      = ttl_pkg::KIND_STR_CHAR;
        main_res.char_code = byte_i;
      end else if (byte_i == ttl_pkg::CH_COLON) begin
        main_valid    = 1'b1;
        main_res.kind = ttl_pkg::KIND_COMMAND;
      end else if (!(is_digit || byte_i == ttl_pkg::CH_MINUS ||
                     byte_i == ttl_pkg::CH_HASH || is_space)) begin
        main_valid    = 1'b1;
        main_res.kind = ttl_pkg::KIND_INVALID;
      end
    end

    push_o.push = fire_i && (pre_valid || main_valid);
    push_o.two  = pre_valid && main_valid;
    push_o.r0   = pre_valid ? pre_res : main_res;
    push_o.r1   = main_res;
    push_o.r0.last = !(pre_valid && main_valid);
    push_o.r1.last = 1'b1;
  end

  // next state
  always_comb begin
    mode_d  = mode_q;
    len_d   = len_q;
    int_d   = int_q;
    minus_d = minus_q;
    dot_d   = dot_q;
    frac_d  = frac_q;
    fcnt_d  = fcnt_q;
    line_d  = line_q;
    tline_d = tline_q;
    if (fire_i) begin
      if (eoi_i) begin
        mode_d = ttl_pkg::MODE_IDLE;
      end
      if (str_cont) begin
        len_d = len_q + 1'b1;
      end
      if (num_dot) begin
        dot_d = 1'b1;
      end
      if (num_digit) begin
        if (!dot_q) begin
          int_d = (int_mul > {4'd0, ttl_pkg::MAG_MAX}) ? ttl_pkg::MAG_MAX
                                                       : int_mul[ttl_pkg::MAG_W-1:0];
        end else if (fcnt_q < ttl_pkg::FRAC_LIMIT) begin
          frac_d = frac_mul;
          fcnt_d = fcnt_q + 1'b1;
        end
      end
      if (do_idle) begin
        mode_d = ttl_pkg::MODE_IDLE;
        if (is_str_start) begin
          mode_d  = ttl_pkg::MODE_STRING;
          tline_d = line_q;
          len_d   = ttl_pkg::LEN_W'(1);
        end else if (is_digit || byte_i == ttl_pkg::CH_MINUS) begin
          mode_d  = ttl_pkg::MODE_NUMBER;
          tline_d = line_q;
          int_d   = is_digit ? ttl_pkg::MAG_W'(digit) : '0;
          minus_d = !is_digit;
          dot_d   = 1'b0;
          frac_d  = '0;
          fcnt_d  = '0;
        end else if (byte_i == ttl_pkg::CH_HASH) begin
          mode_d = ttl_pkg::MODE_COMMENT;
        end else if (byte_i == ttl_pkg::CH_LF && line_q != ttl_pkg::LINE_MAX) begin
          line_d = line_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ttl_pkg::MODE_IDLE;
      len_q   <= '0;
      int_q   <= '0;
      minus_q <= 1'b0;
      dot_q   <= 1'b0;
      frac_q  <= '0;
      fcnt_q  <= '0;
      line_q  <= ttl_pkg::LINE_BITS'(1);
      tline_q <= ttl_pkg::LINE_BITS'(1);
    end else begin
      mode_q  <= mode_d;
      len_q   <= len_d;
      int_q   <= int_d;
      minus_q <= minus_d;
      dot_q   <= dot_d;
      frac_q  <= frac_d;
      fcnt_q  <= fcnt_d;
      line_q  <= line_d;
      tline_q <= tline_d;
    end
  end

endmodule

>>> rtl/ttl_out_fifo.sv
`timescale 1ns / 1ps

module ttl_out_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ttl_pkg::push_t   push_i,
  output logic             room_o,
  output logic             valid_o,
  input  logic             ready_i,
  output ttl_pkg::result_t data_o
);

  localparam int unsigned CNT_W = ttl_pkg::FIFO_AW + 1;

  ttl_pkg::result_t                mem_q [ttl_pkg::FIFO_DEPTH];
  logic [ttl_pkg::FIFO_AW-1:0]     wr_q, wr_d, rd_q, rd_d, wr_next;
  logic [CNT_W-1:0]                cnt_q, cnt_d;
  logic                            pop;
  logic [CNT_W-1:0]                n_push;

  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];
  assign pop     = valid_o && ready_i;
  // room for two more beats
  assign room_o  = cnt_q <= CNT_W'(ttl_pkg::FIFO_DEPTH - 2);
  assign wr_next = wr_q + 1'b1;
  assign n_push  = push_i.push ? (push_i.two ? CNT_W'(2) : CNT_W'(1)) : '0;

  always_comb begin
    wr_d  = wr_q + n_push[ttl_pkg::FIFO_AW-1:0];
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + n_push - CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      mem_q[wr_q] <= push_i.r0;
      if (push_i.two) begin
        mem_q[wr_next] <= push_i.r1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
